### design/spi_nor_command_planner_defines.svh
// Assertion macros shared by the SPI NOR command planner RTL.
// Used by the top level; depends on i_clk and i_rst_n in the including scope.
`ifndef SPI_NOR_COMMAND_PLANNER_DEFINES_SVH
`define SPI_NOR_COMMAND_PLANNER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SNP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("snp assertion failed");

// Next-cycle implication, disabled while in reset
`define SNP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("snp assertion failed");

`endif

### design/snp_pkg.sv
// Package for the SPI NOR command planner: types, codes and fixed constants.
// No dependencies; imported by snp_ctrl, snp_datapath and the top level.
package snp_pkg;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 13;
    localparam int CNT_W      = 9;
    localparam int BOFF_W     = 12;
    localparam int POLL_W     = 21;
    localparam int AB_W       = 3;
    localparam int LOG_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Sizing constants
    localparam int MAX_LEN         = 4096;
    localparam int PROG_PAGE_BYTES = 256;
    localparam int PAGE_BITS       = $clog2(PROG_PAGE_BYTES);
    localparam int XFER_MAX        = 5 + 256;
    localparam int MAX_RESULTS     = 48;
    // one sector or page costs three descriptors
    localparam int MAX_GROUPS     = MAX_RESULTS / 3;
    // program chunks are bounded by the page, so this span fills all groups
    localparam int PROG_SPAN_MAX  = MAX_GROUPS * PROG_PAGE_BYTES;
    localparam logic [CNT_W-1:0] XLIM_3B = CNT_W'(XFER_MAX - 4);
    localparam logic [CNT_W-1:0] XLIM_4B = CNT_W'(XFER_MAX - 5);

    // SPI NOR command bytes
    localparam logic [7:0] OPC_WREN  = 8'h06;
    localparam logic [7:0] OPC_READ3 = 8'h03;
    localparam logic [7:0] OPC_READ4 = 8'h13;
    localparam logic [7:0] OPC_PP3   = 8'h02;
    localparam logic [7:0] OPC_PP4   = 8'h12;
    localparam logic [7:0] OPC_SE3   = 8'hD8;
    localparam logic [7:0] OPC_SE4   = 8'hDC;
    localparam logic [7:0] OPC_RDSR  = 8'h05;

    localparam logic [CNT_W-1:0]  STATUS_BYTES = CNT_W'(1);
    localparam logic [POLL_W-1:0] POLL_PROG    = POLL_W'(200000);
    localparam logic [POLL_W-1:0] POLL_ERASE   = POLL_W'(2000000);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_PROG  = 2'd1,
        OP_ERASE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_WREN      = 3'd0,
        KIND_READ      = 3'd1,
        KIND_PP        = 3'd2,
        KIND_SE        = 3'd3,
        KIND_WAIT      = 3'd4,
        KIND_RANGE_ERR = 3'd5
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOUR_BYTE = 2'd0,
        REG_CAPACITY  = 2'd1,
        REG_SECTOR    = 2'd2
    } t_cfg_reg;

    // Position inside a WREN / command / wait-ready triple
    typedef enum logic [1:0] {
        PH_WREN = 2'd0,
        PH_CMD  = 2'd1,
        PH_WAIT = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_EMIT,
        S_ERROR
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch the request
        logic check;     // register range and span checks
        logic emit;      // send current descriptor and advance
        logic emit_err;  // send the range-error descriptor
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic op_none;
        logic bad;
        logic empty;
        logic desc_last;
        logic out_free;
    } t_dp_status;

endpackage

### design/snp_ctrl.sv
// Controller state machine of the SPI NOR command planner.
// Depends on snp_pkg; drives snp_datapath through t_ctrl_cmd.
module snp_ctrl
    import snp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.op_none)    n_state = S_IDLE;
                else if (i_status.bad)   n_state = S_ERROR;
                else if (i_status.empty) n_state = S_IDLE;
                else                     n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free && i_status.desc_last) n_state = S_IDLE;
            end
            S_ERROR: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                // no request transfer while reset is held
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            S_ERROR: begin
                o_cmd.emit_err = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/snp_datapath.sv
// Datapath of the SPI NOR command planner: config registers, request checks,
// chunk/sector cursors and the descriptor output register. Depends on snp_pkg.
module snp_datapath
    import snp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request
    input  logic [1:0]            i_op,
    input  logic [ADDR_W-1:0]     i_start_address,
    input  logic [LEN_W-1:0]      i_byte_length,
    // control
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    // descriptor
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_opcode,
    output logic [ADDR_W-1:0]     o_flash_address,
    output logic [AB_W-1:0]       o_address_bytes,
    output logic [CNT_W-1:0]      o_data_count,
    output logic [BOFF_W-1:0]     o_buffer_offset,
    output logic [POLL_W-1:0]     o_poll_limit,
    output logic                  o_last
);

    // configuration
    logic             r_four_byte_mode;
    logic [LOG_W-1:0] r_capacity_log2;
    logic [LOG_W-1:0] r_sector_size_log2;

    // request and cursors
    t_op               r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_off;
    t_phase            r_phase;
    logic [ADDR_W-1:0] r_cur;
    logic [ADDR_W-1:0] r_end;
    logic              r_range_bad;
    logic              r_too_long;
    logic              r_prog_ovf;

    // output register
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [7:0]        r_out_opcode;
    logic [ADDR_W-1:0] r_out_addr;
    logic [AB_W-1:0]   r_out_abytes;
    logic [CNT_W-1:0]  r_out_dcount;
    logic [BOFF_W-1:0] r_out_boff;
    logic [POLL_W-1:0] r_out_poll;
    logic              r_out_last;

    // addressing mode and limits
    logic              known;
    logic              four;
    logic [AB_W-1:0]   abytes;
    logic [ADDR_W-1:0] amask;
    logic [CNT_W-1:0]  xlim;
    logic [ADDR_W-1:0] cap;
    logic [ADDR_W-1:0] sector;
    logic [ADDR_W-1:0] smask;

    assign known  = r_capacity_log2[LOG_W-1];
    assign four   = r_four_byte_mode && (!known || r_capacity_log2 > LOG_W'(24));
    assign abytes = four ? AB_W'(4) : AB_W'(3);
    assign amask  = four ? '1 : ADDR_W'(32'h00FF_FFFF);
    assign xlim   = four ? XLIM_4B : XLIM_3B;
    assign cap    = ADDR_W'(1) << r_capacity_log2;
    assign sector = ADDR_W'(1) << r_sector_size_log2;
    assign smask  = ~(sector - ADDR_W'(1));

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_byte_mode   <= 1'b0;
            r_capacity_log2    <= '0;
            r_sector_size_log2 <= LOG_W'(16);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FOUR_BYTE: r_four_byte_mode   <= i_cfg_data[0];
                REG_CAPACITY:  r_capacity_log2    <= i_cfg_data[LOG_W-1:0];
                REG_SECTOR:    r_sector_size_log2 <= i_cfg_data[LOG_W-1:0];
                default: ;
            endcase
        end
    end

    // Erase span check, evaluated in the decide cycle
    logic [ADDR_W-1:0] span_sectors;
    logic              erase_some;
    logic              erase_big;

    assign erase_some   = r_end > r_cur;
    assign span_sectors = (r_end - r_cur) >> r_sector_size_log2;
    assign erase_big    = erase_some && (span_sectors > ADDR_W'(MAX_GROUPS));

    // Chunk sizing for read and program
    logic [ADDR_W-1:0] addr_now;
    logic [LEN_W-1:0]  remain;
    logic [CNT_W-1:0]  to_page_end;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  chunk;
    logic [LEN_W-1:0]  chunk_end;
    logic              chunk_last;
    logic [ADDR_W-1:0] sec_next;
    logic              sec_last;

    assign addr_now    = r_addr + ADDR_W'(r_off);
    assign remain      = r_len - r_off;
    assign to_page_end = CNT_W'(PROG_PAGE_BYTES) - CNT_W'(addr_now[PAGE_BITS-1:0]);
    always_comb begin
        limit = xlim;
        if (r_op == OP_PROG && to_page_end < xlim) limit = to_page_end;
    end
    assign chunk      = (remain > LEN_W'(limit)) ? limit : remain[CNT_W-1:0];
    assign chunk_end  = r_off + LEN_W'(chunk);
    assign chunk_last = chunk_end == r_len;
    assign sec_next   = r_cur + sector;
    assign sec_last   = sec_next == r_end;

    // Current descriptor
    t_kind             d_kind;
    logic [7:0]        d_opcode;
    logic [ADDR_W-1:0] d_addr;
    logic [AB_W-1:0]   d_abytes;
    logic [CNT_W-1:0]  d_dcount;
    logic [BOFF_W-1:0] d_boff;
    logic [POLL_W-1:0] d_poll;
    logic              d_last;

    always_comb begin
        d_kind   = KIND_WREN;
        d_opcode = OPC_WREN;
        d_addr   = '0;
        d_abytes = '0;
        d_dcount = '0;
        d_boff   = '0;
        d_poll   = '0;
        d_last   = 1'b0;
        case (r_op)
            OP_READ: begin
                d_kind   = KIND_READ;
                d_opcode = four ? OPC_READ4 : OPC_READ3;
                d_addr   = addr_now & amask;
                d_abytes = abytes;
                d_dcount = chunk;
                d_boff   = r_off[BOFF_W-1:0];
                d_last   = chunk_last;
            end
            OP_PROG, OP_ERASE: begin
                case (r_phase)
                    PH_CMD: begin
                        d_abytes = abytes;
                        if (r_op == OP_PROG) begin
                            d_kind   = KIND_PP;
                            d_opcode = four ? OPC_PP4 : OPC_PP3;
                            d_addr   = addr_now & amask;
                            d_dcount = chunk;
                            d_boff   = r_off[BOFF_W-1:0];
                        end else begin
                            d_kind   = KIND_SE;
                            d_opcode = four ? OPC_SE4 : OPC_SE3;
                            d_addr   = r_cur & amask;
                        end
                    end
                    PH_WAIT: begin
                        d_kind   = KIND_WAIT;
                        d_opcode = OPC_RDSR;
                        d_dcount = STATUS_BYTES;
                        d_poll   = (r_op == OP_PROG) ? POLL_PROG : POLL_ERASE;
                        d_last   = (r_op == OP_PROG) ? chunk_last : sec_last;
                    end
                    default: begin
                        d_kind = KIND_WREN;
                    end
                endcase
            end
            default: begin
                d_last = 1'b1;
            end
        endcase
    end

    // Request latch, checks and cursor advance
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_op);
            r_addr  <= i_start_address;
            r_len   <= i_byte_length;
            r_off   <= '0;
            r_phase <= PH_WREN;
        end
        if (i_cmd.check) begin
            r_range_bad <= known && ((r_addr > cap) ||
                           (ADDR_W'(r_len) > (cap - r_addr)));
            r_too_long  <= r_len > LEN_W'(MAX_LEN);
            r_prog_ovf  <= (r_op == OP_PROG) && (r_len != '0) &&
                           ((14'(r_addr[PAGE_BITS-1:0]) + 14'(r_len)) > 14'(PROG_SPAN_MAX));
            r_cur       <= r_addr & smask;
            r_end       <= (r_addr + ADDR_W'(r_len) + ~smask) & smask;
        end
        if (i_cmd.emit) begin
            case (r_op)
                OP_READ: begin
                    r_off <= chunk_end;
                end
                OP_PROG, OP_ERASE: begin
                    case (r_phase)
                        PH_WREN: r_phase <= PH_CMD;
                        PH_CMD:  r_phase <= PH_WAIT;
                        default: begin
                            r_phase <= PH_WREN;
                            if (r_op == OP_PROG) r_off <= chunk_end;
                            else                 r_cur <= sec_next;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_out_kind   <= KIND_RANGE_ERR;
            r_out_opcode <= '0;
            r_out_addr   <= '0;
            r_out_abytes <= '0;
            r_out_dcount <= '0;
            r_out_boff   <= '0;
            r_out_poll   <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_kind   <= d_kind;
            r_out_opcode <= d_opcode;
            r_out_addr   <= d_addr;
            r_out_abytes <= d_abytes;
            r_out_dcount <= d_dcount;
            r_out_boff   <= d_boff;
            r_out_poll   <= d_poll;
            r_out_last   <= d_last;
        end
    end

    // Status to controller
    always_comb begin
        o_status.op_none   = r_op == OP_NONE;
        o_status.bad       = r_range_bad || r_too_long || r_prog_ovf ||
                             (r_op == OP_ERASE && erase_big);
        o_status.empty     = (r_op == OP_ERASE) ? !erase_some : (r_len == '0);
        o_status.desc_last = d_last;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_opcode        = r_out_opcode;
    assign o_flash_address = r_out_addr;
    assign o_address_bytes = r_out_abytes;
    assign o_data_count    = r_out_dcount;
    assign o_buffer_offset = r_out_boff;
    assign o_poll_limit    = r_out_poll;
    assign o_last          = r_out_last;

endmodule

### design/spi_nor_command_planner.sv
// SPI NOR command planner. One request (read, program, erase region) is
// taken, checked against the configured capacity and turned into an ordered
// list of transfer descriptors, the final one flagged with o_last. After the
// request is accepted, a check state registers the range and length checks
// and a decide state evaluates the erase-span check; descriptors then leave
// one per cycle while the output side takes them, out of a single output
// register. At most 48 descriptors are produced; a request that is out of
// range, longer than 4096 bytes or would need more yields one range-error
// descriptor instead. A new request is taken once the last descriptor sits
// in the output register. Configuration writes are accepted whenever reset
// is released and must only be issued while idle.
// Depends on snp_pkg, snp_ctrl, snp_datapath and the defines header.
`include "spi_nor_command_planner_defines.svh"

module spi_nor_command_planner
    import snp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_op,
    input  logic [ADDR_W-1:0]     i_start_address,
    input  logic [LEN_W-1:0]      i_byte_length,
    // descriptor channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_opcode,
    output logic [ADDR_W-1:0]     o_flash_address,
    output logic [AB_W-1:0]       o_address_bytes,
    output logic [CNT_W-1:0]      o_data_count,
    output logic [BOFF_W-1:0]     o_buffer_offset,
    output logic [POLL_W-1:0]     o_poll_limit,
    output logic                  o_last
);

    t_ctrl_cmd  cmd;
    t_dp_status status;
    logic       addr_kind;

    // config registers hold their reset values while reset is low
    assign o_cfg_ready = i_rst_n;

    snp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    snp_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_op            (i_op),
        .i_start_address (i_start_address),
        .i_byte_length   (i_byte_length),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_opcode        (o_opcode),
        .o_flash_address (o_flash_address),
        .o_address_bytes (o_address_bytes),
        .o_data_count    (o_data_count),
        .o_buffer_offset (o_buffer_offset),
        .o_poll_limit    (o_poll_limit),
        .o_last          (o_last)
    );

    // kinds that carry address bytes
    assign addr_kind = (o_kind == KIND_READ) || (o_kind == KIND_PP) || (o_kind == KIND_SE);

    // a request transfer makes the block busy for the check cycles
    `SNP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    // a range error stands alone
    `SNP_ASSERT_NOW(a_err_is_last, o_out_valid && o_kind == KIND_RANGE_ERR, o_last)
    // only wait-ready carries a poll limit
    `SNP_ASSERT_NOW(a_poll_on_wait, o_out_valid && o_poll_limit != '0, o_kind == KIND_WAIT)
    // address bytes only on addressed commands
    `SNP_ASSERT_NOW(a_addr_kinds, o_out_valid && o_address_bytes != '0, addr_kind)

endmodule
